// ===== hdl/axis_slot_datum_table_top_defines.svh =====
// Assertion macros for the slot datum table.
`ifndef AXIS_SLOT_DATUM_TABLE_TOP_DEFINES_SVH
`define AXIS_SLOT_DATUM_TABLE_TOP_DEFINES_SVH
// Implication check sampled on the rising clock, disabled in reset.
`define ASDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication check.
`define ASDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/asdt_pkg.sv =====
// ----------------------------------------------------------------------------
// asdt_pkg
// Shared constants and types of the slot datum table.
// ----------------------------------------------------------------------------
package asdt_pkg;
    localparam int SLOT_COUNT = 4;
    localparam int NODE_COUNT = 16;
    localparam int SW = 2;
    localparam int NW = 4;
    localparam logic [4:0] NO_NODE = 5'd16;
    localparam logic [2:0] NO_SLOT = 3'(SLOT_COUNT);

    typedef enum logic [3:0] {
        OP_BIND = 4'd0, OP_UNBIND = 4'd1, OP_SET_LATCH = 4'd2, OP_REC_ORIGIN = 4'd3,
        OP_INV_ORIGIN = 4'd4, OP_INV_ALL = 4'd5, OP_REC_PARK = 4'd6,
        OP_FORGET_PARK = 4'd7, OP_CHECK_PARK = 4'd8, OP_RECONCILE = 4'd9,
        OP_CLEAR_MAP = 4'd10, OP_QUERY = 4'd11
    } t_op;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  slot;
        logic [3:0]  node;
        logic        flag;
        logic        ack;
        logic        tail;
        logic [31:0] pos;
        logic [31:0] msteps;
        logic        estop;
        logic        stopalarm;
        logic [15:0] en_mask;
    } t_cmd;

    typedef struct packed {
        logic [4:0]  slot_node_id;
        logic [2:0]  node_slot_index;
        logic        origin_is_valid;
        logic        park_has_moved;
        logic [31:0] slot_position;
        logic [3:0]  homed_mask;
        logic [3:0]  latched_mask;
        logic [3:0]  enabled_mask;
    } t_res;
endpackage

// ===== hdl/asdt_node_mem.sv =====
// ----------------------------------------------------------------------------
// asdt_node_mem
// Per-node datum offset and park counter memories with registered reads.
// ----------------------------------------------------------------------------
module asdt_node_mem (
    input  logic        i_clk,
    input  logic [3:0]  i_raddr,
    input  logic        i_dwe,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_dwdata,
    input  logic        i_pwe,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_drdata,
    output logic [31:0] o_prdata
);
    import asdt_pkg::*;
    logic [31:0] r_dmem [NODE_COUNT];
    logic [31:0] r_pmem [NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_dwe) begin
            r_dmem[i_waddr] <= i_dwdata;
        end
        if (i_pwe) begin
            r_pmem[i_waddr] <= i_pwdata;
        end
        o_drdata <= r_dmem[i_raddr];
        o_prdata <= r_pmem[i_raddr];
    end
endmodule

// ===== hdl/axis_slot_datum_table_top.sv =====
// ----------------------------------------------------------------------------
// axis_slot_datum_table_top
// Slot-to-node axis map with per-node datum and park bookkeeping.
// ----------------------------------------------------------------------------
// One command item enters on the slave stream; one result item leaves on the
// master stream for each command. A command is accepted when the block is
// free; the node memories are read in the accept cycle and the command is
// applied in the next cycle, when the result is registered. The result is
// valid from the edge that applies the command. A new command is taken only
// after the last one has passed the memory read and the result handshake
// and the freed input has shown ready again.
// The result register holds while the receiver stalls, and no new command is
// taken until the result has been taken. Reset unbinds every slot and clears
// all flag bits and slot positions; the datum memory is treated as zero
// through its valid bits and the park memory is ignored through its seen
// bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module axis_slot_datum_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: operation[3:0] slot[5:4] node[9:6] flag[10] ack_present[11]
    // has_tail[12] position[44:13] machine_steps[76:45] machine_in_estop[77]
    // alarm_is_stop[78] node_enabled_mask[94:79], zero fill to 96.
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: slot_node_id[4:0] node_slot_index[7:5] origin_is_valid[8]
    // park_has_moved[9] slot_position[41:10] homed_mask[45:42]
    // latched_mask[49:46] enabled_mask[53:50], zero fill to 56.
    output logic [55:0] m_axis_tdata
);
    import asdt_pkg::*;
    `include "axis_slot_datum_table_top_defines.svh"

    logic        r_busy, r_act;
    t_cmd        r_cmd;
    t_res        r_res;
    logic [4:0]  r_bind [SLOT_COUNT];
    logic [31:0] r_spos [SLOT_COUNT];
    logic [15:0] r_dvalid, r_latch, r_seen;
    logic [3:0]  r_homed, r_slat, r_en;
    logic        r_stop;
    logic [31:0] w_doff, w_park;
    t_cmd        w_in;

    logic [4:0]  n_bind [SLOT_COUNT];
    logic [31:0] n_spos [SLOT_COUNT];
    logic [15:0] n_dvalid, n_latch, n_seen;
    logic [3:0]  n_homed, n_slat, n_en;
    logic        n_stop, n_moved, w_dwe, w_pwe;
    logic [31:0] w_dw;
    logic [2:0]  w_ls, w_ls2;
    t_res        n_res;

    assign w_in = {s_axis_tdata[3:0], s_axis_tdata[5:4], s_axis_tdata[9:6],
        s_axis_tdata[10], s_axis_tdata[11], s_axis_tdata[12], s_axis_tdata[44:13],
        s_axis_tdata[76:45], s_axis_tdata[77], s_axis_tdata[78], s_axis_tdata[94:79]};
    assign s_axis_tready = !r_busy;
    assign m_axis_tdata = {2'b00, r_res.enabled_mask, r_res.latched_mask,
        r_res.homed_mask, r_res.slot_position, r_res.park_has_moved,
        r_res.origin_is_valid, r_res.node_slot_index, r_res.slot_node_id};

    asdt_node_mem u_mem (
        .i_clk(i_clk), .i_raddr(w_in.node), .i_dwe(w_dwe), .i_waddr(r_cmd.node),
        .i_dwdata(w_dw), .i_pwe(w_pwe), .i_pwdata(r_cmd.pos),
        .o_drdata(w_doff), .o_prdata(w_park)
    );

    always_comb begin
        logic [31:0] doff;
        doff = r_dvalid[r_cmd.node] ? w_doff : 32'd0;
        n_bind = r_bind; n_spos = r_spos; n_dvalid = r_dvalid; n_latch = r_latch;
        n_seen = r_seen; n_homed = r_homed; n_slat = r_slat; n_en = r_en;
        n_stop = r_stop; n_moved = 1'b0; w_dwe = 1'b0; w_pwe = 1'b0;
        w_dw = r_cmd.pos - r_cmd.msteps;
        w_ls = NO_SLOT;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_bind[i] == {1'b0, r_cmd.node}) w_ls = 3'(i);
        end
        case (r_cmd.op)
            OP_BIND: begin
                n_bind[r_cmd.slot] = {1'b0, r_cmd.node};
                if (!(r_cmd.ack && r_cmd.flag)) begin
                    n_dvalid[r_cmd.node] = 1'b0;
                    n_seen[r_cmd.node] = 1'b0;
                    if (w_ls < {1'b0, r_cmd.slot}) n_homed[w_ls[1:0]] = 1'b0;
                end
                n_slat[r_cmd.slot] = r_latch[r_cmd.node];
                if (r_cmd.ack && r_cmd.tail && n_dvalid[r_cmd.node]) begin
                    n_spos[r_cmd.slot] = r_cmd.pos - doff;
                    n_homed[r_cmd.slot] = 1'b1;
                end else begin
                    n_spos[r_cmd.slot] = 32'd0;
                    n_homed[r_cmd.slot] = 1'b0;
                end
            end
            OP_UNBIND: begin
                n_bind[r_cmd.slot] = NO_NODE;
                n_spos[r_cmd.slot] = 32'd0;
                n_homed[r_cmd.slot] = 1'b0;
                n_slat[r_cmd.slot] = 1'b0;
            end
            OP_SET_LATCH: begin
                n_latch[r_cmd.node] = r_cmd.flag;
                if (w_ls != NO_SLOT) n_slat[w_ls[1:0]] = r_cmd.flag;
            end
            OP_REC_ORIGIN: begin
                w_dwe = 1'b1;
                n_dvalid[r_cmd.node] = 1'b1;
                if (w_ls != NO_SLOT) begin
                    n_spos[w_ls[1:0]] = r_cmd.msteps;
                    n_homed[w_ls[1:0]] = 1'b1;
                end
            end
            OP_INV_ORIGIN: begin
                n_dvalid[r_cmd.node] = 1'b0;
                n_seen[r_cmd.node] = 1'b0;
                if (w_ls != NO_SLOT) n_homed[w_ls[1:0]] = 1'b0;
            end
            OP_INV_ALL: begin
                n_dvalid = '0; n_seen = '0; n_homed = '0;
            end
            OP_REC_PARK: begin
                w_pwe = 1'b1;
                n_seen[r_cmd.node] = 1'b1;
            end
            OP_FORGET_PARK: n_seen[r_cmd.node] = 1'b0;
            OP_CHECK_PARK: n_moved = r_seen[r_cmd.node] && (w_park != r_cmd.pos);
            OP_RECONCILE: begin
                if (r_cmd.estop || r_cmd.stopalarm) begin
                    if (!r_stop) begin
                        n_dvalid = '0; n_seen = '0; n_homed = '0;
                        n_stop = 1'b1;
                    end
                end else begin
                    n_stop = 1'b0;
                end
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    n_en[i] = !r_bind[i][4] && r_cmd.en_mask[r_bind[i][3:0]];
                end
            end
            OP_CLEAR_MAP: begin
                for (int i = 0; i < SLOT_COUNT; i++) n_bind[i] = NO_NODE;
            end
            default: ;
        endcase
        w_ls2 = NO_SLOT;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (n_bind[i] == {1'b0, r_cmd.node}) w_ls2 = 3'(i);
        end
        n_res.slot_node_id = n_bind[r_cmd.slot];
        n_res.node_slot_index = w_ls2;
        n_res.origin_is_valid = n_dvalid[r_cmd.node];
        n_res.park_has_moved = n_moved;
        n_res.slot_position = n_spos[r_cmd.slot];
        n_res.homed_mask = n_homed;
        n_res.latched_mask = n_slat;
        n_res.enabled_mask = n_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_act <= 1'b0; m_axis_tvalid <= 1'b0;
            r_dvalid <= '0; r_latch <= '0; r_seen <= '0;
            r_homed <= '0; r_slat <= '0; r_en <= '0; r_stop <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_bind[i] <= NO_NODE;
                r_spos[i] <= 32'd0;
            end
        end else begin
            r_act <= 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                r_cmd <= w_in;
                r_busy <= 1'b1;
                r_act <= 1'b1;
            end
            if (r_act) begin
                r_bind <= n_bind; r_spos <= n_spos; r_dvalid <= n_dvalid;
                r_latch <= n_latch; r_seen <= n_seen; r_homed <= n_homed;
                r_slat <= n_slat; r_en <= n_en; r_stop <= n_stop;
                r_res <= n_res;
                m_axis_tvalid <= 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end

    `ASDT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_busy, !s_axis_tready)
    `ASDT_ASSERT_NXT(a_act_to_valid, i_clk, i_rst_n, r_act, m_axis_tvalid)
    `ASDT_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, m_axis_tvalid, r_busy && !r_act)
endmodule
